@@ hw/rtl/asd_pkg.sv @@
package asd_pkg;

   localparam int DIGIT_W      = 4;
   localparam int WEIGHT_W     = 16;
   localparam int BLEND_DIGITS = WEIGHT_W / DIGIT_W;
   localparam int ROUND_BIAS   = 1 << (WEIGHT_W - 1);
   localparam int TIME_W       = 32;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 16;
   localparam int WARMUP_W     = 6;
   localparam int ONE_G_Q20    = 1 << 20;

   localparam logic [CSR_DATA_W-1:0] RISE_MARGIN_RST = 16'd1434;
   localparam logic [CSR_DATA_W-1:0] QUIET_BAND_RST  = 16'd205;
   localparam logic [CSR_DATA_W-1:0] LOCKOUT_RST     = 16'd250;
   localparam logic [CSR_DATA_W-1:0] TIMEOUT_RST     = 16'd2000;
   localparam logic [WARMUP_W-1:0]   WARMUP_RST      = 6'd50;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RISE_MARGIN = 3'd0,
      CSR_QUIET_BAND  = 3'd1,
      CSR_LOCKOUT     = 3'd2,
      CSR_TIMEOUT     = 3'd3,
      CSR_WARMUP      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_FILT,
      MODE_FAST,
      MODE_SLOW
   } blend_mode_type;

   // q0.16 weights, old and new sum to one
   function automatic logic [WEIGHT_W-1:0] weight_old(blend_mode_type mode);
      logic [WEIGHT_W-1:0] w;
      unique case (mode)
         MODE_FILT: w = 16'd55706;
         MODE_FAST: w = 16'd64225;
         MODE_SLOW: w = 16'd64881;
         default:   w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [WEIGHT_W-1:0] weight_new(blend_mode_type mode);
      logic [WEIGHT_W-1:0] w;
      unique case (mode)
         MODE_FILT: w = 16'd9830;
         MODE_FAST: w = 16'd1311;
         MODE_SLOW: w = 16'd655;
         default:   w = '0;
      endcase
      return w;
   endfunction

endpackage

@@ hw/rtl/asd_if.sv @@
interface asd_req_if #(parameter int SAMPLE_WIDTH = 16) ();
   import asd_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] accel_x;
   logic signed [SAMPLE_WIDTH-1:0] accel_y;
   logic signed [SAMPLE_WIDTH-1:0] accel_z;
   logic [TIME_W-1:0]              time_ms;

   modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

interface asd_rsp_if #(parameter int SAMPLE_WIDTH = 16, parameter int COUNT_WIDTH = 24) ();
   logic                    valid;
   logic                    ready;
   logic [COUNT_WIDTH-1:0]  step_total;
   logic                    step_seen;
   logic                    peak_open;
   logic [SAMPLE_WIDTH-1:0] smoothed_level;

   modport source (output valid, step_total, step_seen, peak_open, smoothed_level, input ready);
   modport sink (input valid, step_total, step_seen, peak_open, smoothed_level, output ready);
endinterface

interface asd_csr_if ();
   import asd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/asd_mag.sv @@
module asd_mag #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0] accel_z,
   output logic                           done,
   output logic [SAMPLE_WIDTH-1:0]        root
);
   import asd_pkg::*;

   localparam int SQ_DIGITS = (SAMPLE_WIDTH + DIGIT_W - 1) / DIGIT_W;
   localparam int SQ_PAD    = SQ_DIGITS * DIGIT_W;
   localparam int PART_W    = SAMPLE_WIDTH + DIGIT_W;
   localparam int RAD_W     = 2 * SAMPLE_WIDTH;
   localparam int RT_CYCLES = (SAMPLE_WIDTH + 1) / 2;
   localparam int RAD_PAD   = 4 * RT_CYCLES;
   localparam int REM_W     = SAMPLE_WIDTH + 3;
   localparam int CNT_W     = $clog2(SAMPLE_WIDTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SAMPLE_WIDTH-1:0] mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic [SQ_PAD-1:0]       dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [RAD_W-1:0]        acc_ff, acc_in;
   logic [RAD_PAD-1:0]      rad_ff, rad_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [SAMPLE_WIDTH-1:0] root_ff, root_in;
   logic                    done_ff, done_in;

   logic [SAMPLE_WIDTH-1:0] abs_x, abs_y, abs_z;
   logic [PART_W-1:0]       part_x, part_y, part_z;
   logic [RAD_W-1:0]        acc_next;
   logic [REM_W-1:0]        rem_a, trial_a, rem_b0, rem_b, trial_b, rem_c;
   logic [SAMPLE_WIDTH-1:0] root_a, root_b;

   assign abs_x = accel_x[SAMPLE_WIDTH-1] ? (~accel_x + 1'b1) : accel_x;
   assign abs_y = accel_y[SAMPLE_WIDTH-1] ? (~accel_y + 1'b1) : accel_y;
   assign abs_z = accel_z[SAMPLE_WIDTH-1] ? (~accel_z + 1'b1) : accel_z;

   // sum of squares, one digit of each multiplier per cycle, msb first
   assign part_x   = mx_ff * dx_ff[SQ_PAD-1 -: DIGIT_W];
   assign part_y   = my_ff * dy_ff[SQ_PAD-1 -: DIGIT_W];
   assign part_z   = mz_ff * dz_ff[SQ_PAD-1 -: DIGIT_W];
   assign acc_next = (acc_ff << DIGIT_W) + RAD_W'(part_x) + RAD_W'(part_y) + RAD_W'(part_z);

   // two root bits per cycle
   always_comb begin
      rem_a   = {rem_ff[REM_W-3:0], rad_ff[RAD_PAD-1 -: 2]};
      trial_a = REM_W'({root_ff, 2'b01});
      if (rem_a >= trial_a) begin
         rem_b0 = rem_a - trial_a;
         root_a = {root_ff[SAMPLE_WIDTH-2:0], 1'b1};
      end else begin
         rem_b0 = rem_a;
         root_a = {root_ff[SAMPLE_WIDTH-2:0], 1'b0};
      end
      rem_b   = {rem_b0[REM_W-3:0], rad_ff[RAD_PAD-3 -: 2]};
      trial_b = REM_W'({root_a, 2'b01});
      if (rem_b >= trial_b) begin
         rem_c  = rem_b - trial_b;
         root_b = {root_a[SAMPLE_WIDTH-2:0], 1'b1};
      end else begin
         rem_c  = rem_b;
         root_b = {root_a[SAMPLE_WIDTH-2:0], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      mz_in    = mz_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      dz_in    = dz_ff;
      acc_in   = acc_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mx_in    = abs_x;
               my_in    = abs_y;
               mz_in    = abs_z;
               dx_in    = SQ_PAD'(abs_x);
               dy_in    = SQ_PAD'(abs_y);
               dz_in    = SQ_PAD'(abs_z);
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            acc_in = acc_next;
            dx_in  = dx_ff << DIGIT_W;
            dy_in  = dy_ff << DIGIT_W;
            dz_in  = dz_ff << DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQ_DIGITS - 1)) begin
               rad_in   = RAD_PAD'(acc_next);
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in  = rad_ff << 4;
            rem_in  = rem_c;
            root_in = root_b;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RT_CYCLES - 1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mz_ff   <= mz_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ hw/rtl/accel_step_detector_top.sv @@
// Step detector for a stream of three-axis accelerometer words. Each accepted word
// gives exactly one result word carrying the saturating step count, a new-step flag,
// the open-peak flag and the smoothed magnitude in Q4.12 g. One word is processed at a
// time: digit-serial squaring, the two-bit-per-cycle square root, then IIR updates of
// the filtered level and of the baseline on a shared digit-serial multiply-accumulate,
// and the step decision. The baseline update is skipped when warm-up is over and the
// filtered level is not within the quiet band of the baseline. The next word is taken
// only once the previous word's result is registered. A result waiting at the output
// does not block the next word until that word's result is ready. Register writes are
// accepted in every cycle and take effect at once.
module accel_step_detector_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 24
) (
   input logic        clock,
   input logic        reset,
   asd_req_if.sink    req_ch,
   asd_rsp_if.source  rsp_ch,
   asd_csr_if.sink    csr_ch
);
   import asd_pkg::*;

   localparam int FW     = SAMPLE_WIDTH + 8;
   localparam int ACC_W  = FW + WEIGHT_W;
   localparam int PART_W = FW + DIGIT_W;
   localparam int CMP_W  = ((FW > CSR_DATA_W + 8) ? FW : CSR_DATA_W + 8) + 1;
   localparam int KCNT_W = $clog2(BLEND_DIGITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_FILT,
      ST_BSEL,
      ST_BASE,
      ST_DECIDE
   } state_type;

   state_type               state_ff, state_in;
   logic [CSR_DATA_W-1:0]   rise_ff, rise_in, band_ff, band_in;
   logic [CSR_DATA_W-1:0]   lock_ff, lock_in, tmo_ff, tmo_in;
   logic [WARMUP_W-1:0]     warmup_ff, warmup_in, warm_cnt_ff, warm_cnt_in;
   logic [FW-1:0]           filt_ff, filt_in, base_ff, base_in;
   logic [TIME_W-1:0]       last_ff, last_in, now_ff, now_in;
   logic                    peak_ff, peak_in;
   logic [COUNT_WIDTH-1:0]  tally_ff, tally_in;
   logic [FW-1:0]           op_old_ff, op_old_in, op_new_ff, op_new_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [KCNT_W-1:0]       k_ff, k_in;
   blend_mode_type          mode_ff, mode_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [COUNT_WIDTH-1:0]  out_total_ff, out_total_in;
   logic                    out_seen_ff, out_seen_in, out_open_ff, out_open_in;
   logic [SAMPLE_WIDTH-1:0] out_level_ff, out_level_in;

   logic                    req_fire, mag_done, rsp_free;
   logic [SAMPLE_WIDTH-1:0] mag_root;
   logic [WEIGHT_W-1:0]     w_old, w_new;
   logic [DIGIT_W-1:0]      dig_old, dig_new;
   logic [PART_W-1:0]       part_old, part_new;
   logic [ACC_W-1:0]        acc_next, acc_rnd;
   logic [FW-1:0]           blend_res, diff;
   logic [CMP_W-1:0]        band_q, margin_q;
   logic [TIME_W-1:0]       elapsed;
   logic                    warm, in_band, above, below, step, timed_out, peak_next;
   logic [COUNT_WIDTH-1:0]  tally_next;

   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_vld_ff || rsp_ch.ready;

   asd_mag #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mag (
      .clock   (clock),
      .reset   (reset),
      .start   (req_fire),
      .accel_x (req_ch.accel_x),
      .accel_y (req_ch.accel_y),
      .accel_z (req_ch.accel_z),
      .done    (mag_done),
      .root    (mag_root)
   );

   // shared iir update, one weight digit per cycle, msb first
   assign w_old     = weight_old(mode_ff);
   assign w_new     = weight_new(mode_ff);
   assign dig_old   = w_old[int'(k_ff) * DIGIT_W +: DIGIT_W];
   assign dig_new   = w_new[int'(k_ff) * DIGIT_W +: DIGIT_W];
   assign part_old  = op_old_ff * dig_old;
   assign part_new  = op_new_ff * dig_new;
   assign acc_next  = (acc_ff << DIGIT_W) + ACC_W'(part_old) + ACC_W'(part_new);
   // round half up on the last digit
   assign acc_rnd   = acc_next + ACC_W'(ROUND_BIAS);
   assign blend_res = acc_rnd[ACC_W-1 -: FW];

   assign band_q   = CMP_W'({band_ff, 8'h00});
   assign margin_q = CMP_W'({rise_ff, 8'h00});
   assign diff     = (filt_ff >= base_ff) ? (filt_ff - base_ff) : (base_ff - filt_ff);
   assign warm     = warm_cnt_ff < warmup_ff;
   assign in_band  = CMP_W'(diff) < band_q;

   assign elapsed    = now_ff - last_ff;
   assign above      = CMP_W'(filt_ff) > (CMP_W'(base_ff) + margin_q);
   assign below      = CMP_W'(filt_ff) < (CMP_W'(base_ff) + band_q);
   assign step       = !peak_ff && above && (elapsed > TIME_W'(lock_ff));
   assign timed_out  = !step && (elapsed > TIME_W'(tmo_ff));
   assign peak_next  = (peak_ff || step) && !below && !timed_out;
   assign tally_next = (step && (tally_ff != {COUNT_WIDTH{1'b1}})) ? tally_ff + 1'b1 : tally_ff;

   always_comb begin
      state_in     = state_ff;
      rise_in      = rise_ff;
      band_in      = band_ff;
      lock_in      = lock_ff;
      tmo_in       = tmo_ff;
      warmup_in    = warmup_ff;
      warm_cnt_in  = warm_cnt_ff;
      filt_in      = filt_ff;
      base_in      = base_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      peak_in      = peak_ff;
      tally_in     = tally_ff;
      op_old_in    = op_old_ff;
      op_new_in    = op_new_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      mode_in      = mode_ff;
      rsp_vld_in   = rsp_vld_ff;
      out_total_in = out_total_ff;
      out_seen_in  = out_seen_ff;
      out_open_in  = out_open_ff;
      out_level_in = out_level_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_RISE_MARGIN: rise_in   = csr_ch.data;
            CSR_QUIET_BAND:  band_in   = csr_ch.data;
            CSR_LOCKOUT:     lock_in   = csr_ch.data;
            CSR_TIMEOUT:     tmo_in    = csr_ch.data;
            CSR_WARMUP:      warmup_in = csr_ch.data[WARMUP_W-1:0];
            default: ;
         endcase
      end

      if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in   = req_ch.time_ms;
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            if (mag_done) begin
               op_old_in = filt_ff;
               op_new_in = {mag_root, 8'h00};
               acc_in    = '0;
               k_in      = KCNT_W'(BLEND_DIGITS - 1);
               mode_in   = MODE_FILT;
               state_in  = ST_FILT;
            end
         end
         ST_FILT: begin
            acc_in = acc_next;
            k_in   = k_ff - 1'b1;
            if (k_ff == '0) begin
               filt_in  = blend_res;
               state_in = ST_BSEL;
            end
         end
         ST_BSEL: begin
            op_old_in = base_ff;
            op_new_in = filt_ff;
            acc_in    = '0;
            k_in      = KCNT_W'(BLEND_DIGITS - 1);
            priority if (warm) begin
               mode_in     = MODE_FAST;
               warm_cnt_in = warm_cnt_ff + 1'b1;
               state_in    = ST_BASE;
            end else if (in_band) begin
               mode_in  = MODE_SLOW;
               state_in = ST_BASE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_BASE: begin
            acc_in = acc_next;
            k_in   = k_ff - 1'b1;
            if (k_ff == '0) begin
               base_in  = blend_res;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               tally_in = tally_next;
               peak_in  = peak_next;
               if (step) begin
                  last_in = now_ff;
               end
               out_total_in = tally_next;
               out_seen_in  = step;
               out_open_in  = peak_next;
               out_level_in = filt_ff[FW-1:8];
               rsp_vld_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      op_old_ff    <= op_old_in;
      op_new_ff    <= op_new_in;
      acc_ff       <= acc_in;
      k_ff         <= k_in;
      mode_ff      <= mode_in;
      out_total_ff <= out_total_in;
      out_seen_ff  <= out_seen_in;
      out_open_ff  <= out_open_in;
      out_level_ff <= out_level_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         rise_ff     <= RISE_MARGIN_RST;
         band_ff     <= QUIET_BAND_RST;
         lock_ff     <= LOCKOUT_RST;
         tmo_ff      <= TIMEOUT_RST;
         warmup_ff   <= WARMUP_RST;
         warm_cnt_ff <= '0;
         filt_ff     <= FW'(ONE_G_Q20);
         base_ff     <= FW'(ONE_G_Q20);
         last_ff     <= '0;
         peak_ff     <= 1'b0;
         tally_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rise_ff     <= rise_in;
         band_ff     <= band_in;
         lock_ff     <= lock_in;
         tmo_ff      <= tmo_in;
         warmup_ff   <= warmup_in;
         warm_cnt_ff <= warm_cnt_in;
         filt_ff     <= filt_in;
         base_ff     <= base_in;
         last_ff     <= last_in;
         peak_ff     <= peak_in;
         tally_ff    <= tally_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.step_total     = out_total_ff;
   assign rsp_ch.step_seen      = out_seen_ff;
   assign rsp_ch.peak_open      = out_open_ff;
   assign rsp_ch.smoothed_level = out_level_ff;

endmodule

@@ sim/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import asd_pkg::*;

   localparam int SAMPLE_W     = 16;
   localparam int COUNT_W      = 24;
   localparam int LEVEL_W      = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_CYCLES = 400;
   localparam int REPORT_MAX   = 10;

   // q0.16 filter weights
   localparam int unsigned FILT_KEEP = 55706;
   localparam int unsigned FILT_TAKE = 9830;
   localparam int unsigned FAST_KEEP = 64225;
   localparam int unsigned FAST_TAKE = 1311;
   localparam int unsigned SLOW_KEEP = 64881;
   localparam int unsigned SLOW_TAKE = 655;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic               seen;
      logic               peak;
      logic [LEVEL_W-1:0] level;
   } step_word_type;

   logic clock;
   logic reset;

   asd_req_if #(.SAMPLE_WIDTH(SAMPLE_W)) req_ch ();
   asd_rsp_if #(.SAMPLE_WIDTH(SAMPLE_W), .COUNT_WIDTH(COUNT_W)) rsp_ch ();
   asd_csr_if csr_ch ();

   accel_step_detector_top #(
      .SAMPLE_WIDTH(SAMPLE_W),
      .COUNT_WIDTH (COUNT_W)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // register copies
   logic [CSR_DATA_W-1:0] cfg_rise_margin;
   logic [CSR_DATA_W-1:0] cfg_quiet_band;
   logic [CSR_DATA_W-1:0] cfg_lockout;
   logic [CSR_DATA_W-1:0] cfg_timeout;
   logic [WARMUP_W-1:0]   cfg_warmup;

   // gait tracker state
   logic [SAMPLE_W+7:0] filt_q20;
   logic [SAMPLE_W+7:0] base_q20;
   logic [WARMUP_W-1:0] warm_count;
   logic [TIME_W-1:0]   last_step_ms;
   logic                peak_active;
   logic [COUNT_W-1:0]  steps_counted;

   step_word_type step_reports[$];

   logic [TIME_W-1:0] now_ms;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_request;
   int stall_left;
   int samples_sent;
   int words_checked;
   int steps_flagged;
   int reg_writes;
   int mismatches;
   int cycle_count;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned axis_square(logic signed [SAMPLE_W-1:0] a);
      longint m;
      m = a;
      if (m < 0) m = -m;
      return m * m;
   endfunction

   function automatic logic [SAMPLE_W-1:0] floor_root(logic [31:0] v);
      logic [SAMPLE_W-1:0] r;
      longint unsigned c;
      r = '0;
      for (int b = SAMPLE_W - 1; b >= 0; b--) begin
         c = r | (16'd1 << b);
         if (c * c <= 64'(v)) r = c[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [SAMPLE_W+7:0] mix_q20(logic [SAMPLE_W+7:0] prior,
                                                  logic [SAMPLE_W+7:0] fresh,
                                                  int unsigned keep, int unsigned take);
      longint unsigned acc;
      acc = 64'(prior) * 64'(keep) + 64'(fresh) * 64'(take) + 64'd32768;
      return acc[SAMPLE_W+23:16];
   endfunction

   task automatic track_gait(input logic signed [SAMPLE_W-1:0] ax, ay, az,
                             input logic [TIME_W-1:0] t);
      longint unsigned sq;
      longint unsigned fq;
      longint unsigned bq;
      longint unsigned band_q20;
      longint unsigned gap;
      logic [SAMPLE_W+7:0] raw_q20;
      logic [TIME_W-1:0] since_step;
      step_word_type w;
      sq = axis_square(ax) + axis_square(ay) + axis_square(az);
      raw_q20 = {floor_root(sq[31:0]), 8'd0};
      filt_q20 = mix_q20(filt_q20, raw_q20, FILT_KEEP, FILT_TAKE);
      band_q20 = 64'(cfg_quiet_band) << 8;
      if (warm_count < cfg_warmup) begin
         base_q20 = mix_q20(base_q20, filt_q20, FAST_KEEP, FAST_TAKE);
         warm_count = warm_count + 1'b1;
      end else begin
         fq = filt_q20;
         bq = base_q20;
         gap = (fq >= bq) ? fq - bq : bq - fq;
         if (gap < band_q20) base_q20 = mix_q20(base_q20, filt_q20, SLOW_KEEP, SLOW_TAKE);
      end
      fq = filt_q20;
      bq = base_q20;
      w.seen = 1'b0;
      since_step = t - last_step_ms;
      if (!peak_active && fq > bq + (64'(cfg_rise_margin) << 8) &&
          since_step > 32'(cfg_lockout)) begin
         if (steps_counted != '1) steps_counted = steps_counted + 1'b1;
         peak_active = 1'b1;
         last_step_ms = t;
         w.seen = 1'b1;
      end
      if (peak_active && fq < bq + band_q20) peak_active = 1'b0;
      since_step = t - last_step_ms;
      if (since_step > 32'(cfg_timeout)) peak_active = 1'b0;
      w.total = steps_counted;
      w.peak = peak_active;
      w.level = filt_q20[SAMPLE_W+7:8];
      step_reports.push_back(w);
   endtask

   // sends one sample word, entered and left at a falling edge
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax, ay, az,
                              input logic [TIME_W-1:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.accel_x <= ax;
      req_ch.accel_y <= ay;
      req_ch.accel_z <= az;
      req_ch.time_ms <= t;
      do @(posedge clock); while (!req_ch.ready);
      track_gait(ax, ay, az, t);
      samples_sent++;
      @(negedge clock);
   endtask

   // valid stays high for back-to-back writes; callers lower it
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_RISE_MARGIN: cfg_rise_margin = value;
         CSR_QUIET_BAND:  cfg_quiet_band = value;
         CSR_LOCKOUT:     cfg_lockout = value;
         CSR_TIMEOUT:     cfg_timeout = value;
         CSR_WARMUP:      cfg_warmup = value[WARMUP_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [CSR_DATA_W-1:0] rise, band, lockout, timeout,
                               input logic [CSR_DATA_W-1:0] warmup);
      write_reg(CSR_RISE_MARGIN, rise);
      write_reg(CSR_QUIET_BAND, band);
      write_reg(CSR_LOCKOUT, lockout);
      write_reg(CSR_TIMEOUT, timeout);
      write_reg(CSR_WARMUP, warmup);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (step_reports.size() != 0) @(negedge clock);
   endtask

   task automatic randomize_config();
      if ($urandom_range(3) == 0)
         apply_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom_range(63)));
      else
         apply_config(16'($urandom_range(2500, 300)), 16'($urandom_range(600, 40)),
                      16'($urandom_range(400, 0)), 16'($urandom_range(3000, 100)),
                      16'($urandom_range(63, 0)));
   endtask

   // periodic vertical swing on top of gravity, with tilt and jitter
   task automatic walk_burst(input int len);
      int period;
      int swing;
      int tilt_x;
      int tilt_y;
      int dt;
      int phase;
      int d;
      int wave;
      int jx;
      int jy;
      int jz;
      period = $urandom_range(40, 10);
      swing  = $urandom_range(4000, 800);
      tilt_x = $urandom_range(800, 0);
      tilt_x = tilt_x - 400;
      tilt_y = $urandom_range(800, 0);
      tilt_y = tilt_y - 400;
      dt     = $urandom_range(30, 8);
      phase  = $urandom_range(period - 1, 0);
      for (int k = 0; k < len; k++) begin
         d = 2 * ((phase + k) % period) - period;
         if (d < 0) d = -d;
         wave = (swing * (2 * d - period)) / period;
         jx = $urandom_range(200, 0);
         jy = $urandom_range(200, 0);
         jz = $urandom_range(200, 0);
         jx = jx - 100;
         jy = jy - 100;
         jz = jz - 100;
         if ($urandom_range(49) == 0) now_ms = now_ms - $urandom_range(3000, 1);
         else now_ms = now_ms + dt + $urandom_range(3, 0);
         send_sample(16'(tilt_x + jx), 16'(tilt_y + jy), 16'(4096 + wave + jz), now_ms);
      end
   endtask

   task automatic noise_burst(input int len);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(1) == 0) now_ms = now_ms + $urandom_range(5000, 0);
         else now_ms = $urandom;
         send_sample(16'($urandom), 16'($urandom), 16'($urandom), now_ms);
      end
   endtask

   task automatic test_reset_state();
      send_idle_pct = 20;
      recv_idle_pct = 20;
      send_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'd1);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd2);
      send_sample(-16'sd32768, 16'sd32767, 16'sd0, 32'hFFFF_FFFF);
      send_sample(-16'sd1, 16'sd1, -16'sd4096, 32'h8000_0000);
   endtask

   task automatic test_unknown_index();
      settle();
      for (int i = CSR_SPARE_FIRST; i <= CSR_SPARE_LAST; i++)
         write_reg(i[CSR_INDEX_W-1:0], 16'hFFFF);
      csr_ch.valid <= 1'b0;
      send_sample(16'sd0, 16'sd0, 16'sd4096, 32'd200);
      send_sample(16'sd0, 16'sd0, 16'sd4096, 32'd210);
   endtask

   task automatic test_warmup_cut();
      settle();
      write_reg(CSR_WARMUP, 16'hFFFF);
      csr_ch.valid <= 1'b0;
      send_sample(16'sd100, -16'sd50, 16'sd6000, 32'd220);
      send_sample(16'sd100, -16'sd50, 16'sd6000, 32'd230);
      settle();
      // below the count already reached
      write_reg(CSR_WARMUP, 16'd2);
      csr_ch.valid <= 1'b0;
      send_sample(16'sd100, -16'sd50, 16'sd6000, 32'd240);
      send_sample(16'sd100, -16'sd50, 16'sd6000, 32'd250);
   endtask

   task automatic test_peak_corners();
      settle();
      // margin under band: peak opens and closes on one word
      apply_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd1000);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd1001);
      // timestamp wrap, then a timestamp behind the last step
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'hFFFF_FFF0);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd5);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd1);
      settle();
      apply_config(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
      send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 32'd3000);
      settle();
      // zero timeout: peak closes once time moves on
      apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd5000);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd5000);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd5001);
      settle();
      apply_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd5010);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd75010);
   endtask

   task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
      int start;
      settle();
      randomize_config();
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      now_ms = ($urandom_range(3) == 0) ? 32'hFFFF_F000 : $urandom;
      start = samples_sent;
      while (samples_sent - start < items) begin
         if ($urandom_range(9) == 0) noise_burst($urandom_range(8, 1));
         else walk_burst($urandom_range(80, 20));
      end
   endtask

   task automatic test_output_stall();
      settle();
      randomize_config();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = STALL_CYCLES;
      walk_burst(60);
   endtask

   always @(negedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      step_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (step_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result word: total=%0d seen=%0b peak=%0b level=%h",
                        rsp_ch.step_total, rsp_ch.step_seen, rsp_ch.peak_open,
                        rsp_ch.smoothed_level);
         end else begin
            want = step_reports.pop_front();
            if (rsp_ch.step_total !== want.total || rsp_ch.step_seen !== want.seen ||
                rsp_ch.peak_open !== want.peak || rsp_ch.smoothed_level !== want.level) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("mismatch on word %0d: expected total=%0d seen=%0b peak=%0b level=%h",
                           words_checked, want.total, want.seen, want.peak, want.level);
                  $display("   got total=%0d seen=%0b peak=%0b level=%h",
                           rsp_ch.step_total, rsp_ch.step_seen, rsp_ch.peak_open,
                           rsp_ch.smoothed_level);
               end
            end
            if (rsp_ch.step_seen === 1'b1) steps_flagged++;
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  step_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.accel_x = '0;
      req_ch.accel_y = '0;
      req_ch.accel_z = '0;
      req_ch.time_ms = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      cfg_rise_margin = RISE_MARGIN_RST;
      cfg_quiet_band = QUIET_BAND_RST;
      cfg_lockout = LOCKOUT_RST;
      cfg_timeout = TIMEOUT_RST;
      cfg_warmup = WARMUP_RST;
      filt_q20 = (SAMPLE_W + 8)'(ONE_G_Q20);
      base_q20 = (SAMPLE_W + 8)'(ONE_G_Q20);
      warm_count = '0;
      last_step_ms = '0;
      peak_active = 1'b0;
      steps_counted = '0;
      now_ms = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 0;
      stall_left = 0;
      samples_sent = 0;
      words_checked = 0;
      steps_flagged = 0;
      reg_writes = 0;
      mismatches = 0;
      cycle_count = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_unknown_index();
      test_warmup_cut();
      test_peak_corners();
      test_random_traffic(250, 36, 87);
      test_random_traffic(250, 87, 36);
      test_output_stall();
      test_random_traffic(200, 0, 0);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run summary: %0d samples, %0d words checked, %0d steps, %0d writes",
               samples_sent, words_checked, steps_flagged, reg_writes);
      $display("covered register corners, timestamp wrap, three idle mixes and a %0d-cycle stall",
               STALL_CYCLES);
      if (mismatches == 0 && step_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d words never seen", mismatches, step_reports.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/asd_pkg.sv
hw/rtl/asd_if.sv
hw/rtl/asd_mag.sv
hw/rtl/accel_step_detector_top.sv
sim/testbench.sv
